// ===== rtl/core/threshold_light_debouncer_macros.svh =====
// Assertion macros used by the light debouncer tracker RTL.
`ifndef THRESHOLD_LIGHT_DEBOUNCER_MACROS_SVH
`define THRESHOLD_LIGHT_DEBOUNCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tld_pkg.sv =====
// Package: request/response types, config types and grade helpers.
`timescale 1ns / 1ps

package tld_pkg;

    // command codes
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_CLASS = 2'd1;
    localparam logic [1:0] CMD_SPEED = 2'd2;
    localparam logic [1:0] CMD_NET   = 2'd3;

    // light / grade codes
    localparam logic [1:0] GRADE_TEST   = 2'd0;
    localparam logic [1:0] GRADE_GREEN  = 2'd1;
    localparam logic [1:0] GRADE_YELLOW = 2'd2;
    localparam logic [1:0] GRADE_RED    = 2'd3;

    // config register indexes
    localparam logic [2:0] REG_SIG_GOOD   = 3'd0;
    localparam logic [2:0] REG_SIG_FAIR   = 3'd1;
    localparam logic [2:0] REG_DLY_GOOD   = 3'd2;
    localparam logic [2:0] REG_DLY_FAIR   = 3'd3;
    localparam logic [2:0] REG_LOSS_GOOD  = 3'd4;
    localparam logic [2:0] REG_LOSS_FAIR  = 3'd5;
    localparam logic [2:0] REG_REPEAT     = 3'd6;
    localparam logic [2:0] REG_WEAK_RUN   = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // config reset values
    localparam logic signed [7:0] SIG_GOOD_RST  = -8'sd60;
    localparam logic signed [7:0] SIG_FAIR_RST  = -8'sd70;
    localparam logic [15:0]       DLY_GOOD_RST  = 16'd50;
    localparam logic [15:0]       DLY_FAIR_RST  = 16'd150;
    localparam logic [6:0]        LOSS_GOOD_RST = 7'd2;
    localparam logic [6:0]        LOSS_FAIR_RST = 7'd8;
    localparam logic [7:0]        REPEAT_RST    = 8'd3;
    localparam logic [7:0]        WEAK_RUN_RST  = 8'd3;

    // score bands for 1..6 quality scores
    localparam logic [2:0] SCORE_GREEN_MAX  = 3'd2;
    localparam logic [2:0] SCORE_YELLOW_MAX = 3'd4;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [7:0] signal_dbm;
        logic [15:0]       gateway_delay;
        logic [15:0]       server_delay;
        logic [6:0]        loss_percent;
        logic [2:0]        local_quality;
        logic [2:0]        remote_quality;
        logic              test_ok;
        logic              in_class;
    } t_in_req;

    typedef struct packed {
        logic [1:0] light;
        logic       light_changed;
        logic       weak_notice;
    } t_out_rsp;

    typedef struct packed {
        logic signed [7:0] signal_good_level;
        logic signed [7:0] signal_fair_level;
        logic [15:0]       delay_good_limit;
        logic [15:0]       delay_fair_limit;
        logic [6:0]        loss_good_limit;
        logic [6:0]        loss_fair_limit;
        logic [7:0]        repeat_needed;
        logic [7:0]        weak_run_needed;
    } t_cfg;

    // grades produced by the comparator stage
    typedef struct packed {
        logic [1:0] probe_grade;
        logic [1:0] class_grade;
        logic [1:0] speed_grade;
    } t_grades;

    function automatic logic [1:0] grade_score(input logic [2:0] q);
        logic [1:0] g;
        if (q <= SCORE_GREEN_MAX) begin
            g = GRADE_GREEN;
        end else if (q <= SCORE_YELLOW_MAX) begin
            g = GRADE_YELLOW;
        end else begin
            g = GRADE_RED;
        end
        return g;
    endfunction

endpackage

// ===== rtl/core/tld_cfg_regs.sv =====
// Configuration register file with plain write port.
`timescale 1ns / 1ps

module tld_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tld_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tld_pkg::t_cfg                   o_cfg
);
    import tld_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signal_good_level <= SIG_GOOD_RST;
            r_cfg.signal_fair_level <= SIG_FAIR_RST;
            r_cfg.delay_good_limit  <= DLY_GOOD_RST;
            r_cfg.delay_fair_limit  <= DLY_FAIR_RST;
            r_cfg.loss_good_limit   <= LOSS_GOOD_RST;
            r_cfg.loss_fair_limit   <= LOSS_FAIR_RST;
            r_cfg.repeat_needed     <= REPEAT_RST;
            r_cfg.weak_run_needed   <= WEAK_RUN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIG_GOOD:  r_cfg.signal_good_level <= i_cfg_data[7:0];
                REG_SIG_FAIR:  r_cfg.signal_fair_level <= i_cfg_data[7:0];
                REG_DLY_GOOD:  r_cfg.delay_good_limit  <= i_cfg_data;
                REG_DLY_FAIR:  r_cfg.delay_fair_limit  <= i_cfg_data;
                REG_LOSS_GOOD: r_cfg.loss_good_limit   <= i_cfg_data[6:0];
                REG_LOSS_FAIR: r_cfg.loss_fair_limit   <= i_cfg_data[6:0];
                REG_REPEAT:    r_cfg.repeat_needed     <= i_cfg_data[7:0];
                REG_WEAK_RUN:  r_cfg.weak_run_needed   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tld_grader.sv =====
// Threshold comparators: probe, class report and speed test grades.
`timescale 1ns / 1ps

module tld_grader (
    input  tld_pkg::t_in_req i_req,
    input  tld_pkg::t_cfg    i_cfg,
    output tld_pkg::t_grades o_grades
);
    import tld_pkg::*;

    logic signed [7:0] sig;
    logic signed [7:0] sig_good;
    logic signed [7:0] sig_fair;
    logic [15:0]       dly;
    logic [1:0]        g_sig;
    logic [1:0]        g_dly;
    logic [1:0]        g_los;
    logic [1:0]        worst;
    logic [2:0]        q_worst;

    assign sig      = i_req.signal_dbm;
    assign sig_good = i_cfg.signal_good_level;
    assign sig_fair = i_cfg.signal_fair_level;

    // larger of the two round-trip times
    assign dly = (i_req.server_delay > i_req.gateway_delay) ?
                 i_req.server_delay : i_req.gateway_delay;

    always_comb begin
        if (sig > sig_good)      g_sig = GRADE_GREEN;
        else if (sig > sig_fair) g_sig = GRADE_YELLOW;
        else                     g_sig = GRADE_RED;

        if (dly < i_cfg.delay_good_limit)      g_dly = GRADE_GREEN;
        else if (dly < i_cfg.delay_fair_limit) g_dly = GRADE_YELLOW;
        else                                   g_dly = GRADE_RED;

        if (i_req.loss_percent < i_cfg.loss_good_limit)      g_los = GRADE_GREEN;
        else if (i_req.loss_percent < i_cfg.loss_fair_limit) g_los = GRADE_YELLOW;
        else                                                 g_los = GRADE_RED;

        worst = g_sig;
        if (g_dly > worst) worst = g_dly;
        if (g_los > worst) worst = g_los;
    end

    assign q_worst = (i_req.local_quality > i_req.remote_quality) ?
                     i_req.local_quality : i_req.remote_quality;

    assign o_grades.probe_grade = worst;
    assign o_grades.class_grade = grade_score(q_worst);
    assign o_grades.speed_grade = grade_score(i_req.local_quality);

endmodule

// ===== rtl/core/tld_tracker.sv =====
// Light state: debouncer, weak-run counter and notice flag.
`timescale 1ns / 1ps

module tld_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tld_pkg::t_in_req  i_req,
    input  tld_pkg::t_grades  i_grades,
    input  tld_pkg::t_cfg     i_cfg,
    output tld_pkg::t_out_rsp o_rsp
);
    import tld_pkg::*;
    `include "threshold_light_debouncer_macros.svh"

    logic [1:0] r_shown,     n_shown;
    logic [1:0] r_cand,      n_cand;
    logic [7:0] r_creps,     n_creps;
    logic [7:0] r_weak_run,  n_weak_run;
    logic       r_given,     n_given;

    logic [1:0] cand;
    logic [7:0] creps_inc;
    logic [7:0] weak_inc;
    logic       changed;
    logic       notice;

    // probe and class candidates share one debouncer
    assign cand      = (i_req.cmd == CMD_PROBE) ? i_grades.probe_grade : i_grades.class_grade;
    assign creps_inc = (r_creps < COUNT_MAX) ? r_creps + 8'd1 : r_creps;
    assign weak_inc  = (r_weak_run < COUNT_MAX) ? r_weak_run + 8'd1 : r_weak_run;

    always_comb begin
        n_shown    = r_shown;
        n_cand     = r_cand;
        n_creps    = r_creps;
        n_weak_run = r_weak_run;
        n_given    = r_given;
        changed    = 1'b0;
        notice     = 1'b0;

        case (i_req.cmd)
            CMD_PROBE, CMD_CLASS: begin
                if (cand == r_shown) begin
                    n_creps = '0;
                end else if (cand == r_cand) begin
                    if (creps_inc >= i_cfg.repeat_needed) begin
                        n_shown = cand;
                        n_creps = '0;
                        changed = 1'b1;
                    end else begin
                        n_creps = creps_inc;
                    end
                end else begin
                    n_cand  = cand;
                    n_creps = 8'd1;
                end

                if (i_req.cmd == CMD_PROBE) begin
                    if (cand >= GRADE_YELLOW) begin
                        n_weak_run = weak_inc;
                        if (weak_inc >= i_cfg.weak_run_needed && !r_given &&
                            !i_req.in_class) begin
                            notice  = 1'b1;
                            n_given = 1'b1;
                        end
                    end else begin
                        n_weak_run = '0;
                    end
                end
            end
            CMD_SPEED: begin
                if (i_req.test_ok) begin
                    n_shown = i_grades.speed_grade;
                    changed = 1'b1;
                end
            end
            CMD_NET: begin
                n_shown    = GRADE_TEST;
                n_cand     = GRADE_TEST;
                n_creps    = '0;
                n_weak_run = '0;
                n_given    = 1'b0;
                changed    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown    <= GRADE_TEST;
            r_cand     <= GRADE_TEST;
            r_creps    <= '0;
            r_weak_run <= '0;
            r_given    <= 1'b0;
        end else if (i_fire) begin
            r_shown    <= n_shown;
            r_cand     <= n_cand;
            r_creps    <= n_creps;
            r_weak_run <= n_weak_run;
            r_given    <= n_given;
        end
    end

    assign o_rsp.light         = n_shown;
    assign o_rsp.light_changed = changed;
    assign o_rsp.weak_notice   = notice;

    `TLD_ASSERT_NOW(a_notice_once, i_clk, i_rst_n, i_fire && r_given, !o_rsp.weak_notice,
        "weak notice raised twice without a network change")
    `TLD_ASSERT_NOW(a_notice_probe_only, i_clk, i_rst_n,
        i_fire && (i_req.cmd != CMD_PROBE), !o_rsp.weak_notice,
        "weak notice raised by a non-probe request")
    `TLD_ASSERT_NEXT(a_net_clears, i_clk, i_rst_n, i_fire && (i_req.cmd == CMD_NET),
        (r_shown == GRADE_TEST) && (r_weak_run == '0) && !r_given,
        "network change did not clear the light state")
    `TLD_ASSERT_NEXT(a_debounce_switch, i_clk, i_rst_n,
        i_fire && (i_req.cmd == CMD_PROBE) && o_rsp.light_changed,
        (r_shown != $past(r_shown)) && (r_creps == '0),
        "debounced switch did not move the light")

endmodule

// ===== rtl/core/threshold_light_debouncer.sv =====
// Top level: input register, grading/debounce logic and output register.
`timescale 1ns / 1ps

// Network quality light with threshold grading and debounce.
// Input channel: i_valid / o_stall carry one request (t_in_req) per accept;
// cmd selects probe sample, class quality report, speed test or network change.
// Output channel: o_valid / i_stall carry one response (t_out_rsp) per request,
// in request order: the light after the request, whether it changed, and
// whether the once-only weak-run notice was raised.
// A request accepted into the input register is processed into the result register,
// which drives o_valid. Throughput: one request per cycle while the output is not
// stalled; the grading comparators and the 8-bit counter updates all sit between
// those two registers, so state written by one request is seen by the next.
// Stall: while i_stall holds, the result register keeps its response, one more
// request may sit in the input register, and then o_stall rises; o_stall follows
// i_stall combinationally so no request is dropped.
// Reset (synchronous, i_rst_n low): both pipeline registers empty, light shows
// testing, counters and notice flag clear, thresholds return to their defaults.
// Config writes (i_cfg_we) are registered; write them only while idle.
module threshold_light_debouncer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  tld_pkg::t_in_req                i_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output tld_pkg::t_out_rsp               o_rsp,
    input  logic                            i_cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tld_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tld_pkg::*;

    t_cfg     cfg;
    t_grades  grades;
    t_out_rsp rsp;

    t_in_req  r_in;
    logic     r_in_vld;
    t_out_rsp r_out;
    logic     r_out_vld;

    logic out_open;   // result register can take a new response
    logic fire;       // request in the input register is processed this cycle
    logic in_take;    // new request accepted this cycle

    assign out_open = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_open;
    assign o_stall  = r_in_vld && !fire;
    assign in_take  = i_valid && !o_stall;

    tld_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tld_grader u_grader (
        .i_req    (r_in),
        .i_cfg    (cfg),
        .o_grades (grades)
    );

    tld_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (r_in),
        .i_grades (grades),
        .i_cfg    (cfg),
        .o_rsp    (rsp)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= rsp;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

endmodule
